[rtl/one_shot_timer_slot_table_defines.svh]
// ----------------------------------------------------------------------------
// One-shot timer slot table: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_SLOT_TABLE_DEFINES_SVH
`define ONE_SHOT_TIMER_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define OSTST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ostst check failed");

// next-cycle implication, checked while out of reset
`define OSTST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ostst check failed");

`endif

[rtl/ostst_pkg.sv]
// ----------------------------------------------------------------------------
// One-shot timer slot table: package
// Request and response types, command and status codes, table sizing.
// ----------------------------------------------------------------------------
package ostst_pkg;

    localparam int NUM_SLOTS = 10;
    localparam int SLOT_W    = 4;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [31:0]       handler_id;
        logic [31:0]       handler_arg;
        logic [31:0]       timeout_ticks;
        logic [SLOT_W-1:0] slot_sel;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic              fired;
        logic [31:0]       fired_handler;
        logic [31:0]       fired_arg;
        logic [31:0]       tick_now;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctl;

endpackage

[rtl/ostst_if.sv]
// ----------------------------------------------------------------------------
// One-shot timer slot table: channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface ostst_req_if;
    logic              valid;
    logic              ready;
    ostst_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ostst_rsp_if;
    logic              valid;
    logic              ready;
    ostst_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ostst_ctrl.sv]
// ----------------------------------------------------------------------------
// One-shot timer slot table: controller
// Sequences capture and execution of one request and owns response valid.
// ----------------------------------------------------------------------------
module ostst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ostst_pkg::t_ctl o_ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        o_ctl.capture = 1'b0;
        o_ctl.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_ctl.execute = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.execute) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/ostst_dp.sv]
// ----------------------------------------------------------------------------
// One-shot timer slot table: datapath
// Slot storage, tick counter, free-slot and due-slot priority encoders.
// ----------------------------------------------------------------------------
module ostst_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ostst_pkg::t_ctl i_ctl,
    input  ostst_pkg::t_req i_req_data,
    output ostst_pkg::t_rsp o_rsp_data
);

    localparam int N  = ostst_pkg::NUM_SLOTS;
    localparam int IW = ostst_pkg::IDX_W;
    localparam int SW = ostst_pkg::SLOT_W;

    ostst_pkg::t_req r_req;
    ostst_pkg::t_rsp r_rsp;
    ostst_pkg::t_rsp n_rsp;

    logic [31:0]   r_tick;
    logic [31:0]   n_tick;
    logic [N-1:0]  r_busy;
    logic [N-1:0]  n_busy;
    logic [31:0]   r_deadline [N];
    logic [31:0]   r_handler  [N];
    logic [31:0]   r_arg      [N];

    logic [31:0]   tick_inc;
    logic [N-1:0]  due;
    logic          fire_hit;
    logic [IW-1:0] fire_idx;
    logic          free_hit;
    logic [IW-1:0] free_idx;
    logic          create_wr;
    logic [IW-1:0] sel_idx;

    assign tick_inc = r_tick + 32'd1;
    assign sel_idx  = r_req.slot_sel[IW-1:0];

    always_comb begin
        for (int i = 0; i < N; i++) begin
            due[i] = r_busy[i] && (tick_inc >= r_deadline[i]);
        end
    end

    always_comb begin
        fire_hit = 1'b0;
        fire_idx = '0;
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (due[i]) begin
                fire_hit = 1'b1;
                fire_idx = IW'(i);
            end
            if (!r_busy[i]) begin
                free_hit = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_tick    = r_tick;
        n_busy    = r_busy;
        create_wr = 1'b0;
        n_rsp     = '0;
        unique case (r_req.cmd)
            ostst_pkg::CMD_CREATE: begin
                if ((r_req.handler_id == 32'd0) || (r_req.timeout_ticks == 32'd0)) begin
                    n_rsp.status = ostst_pkg::STATUS_BAD;
                end else if (free_hit) begin
                    create_wr        = 1'b1;
                    n_busy[free_idx] = 1'b1;
                    n_rsp.status     = ostst_pkg::STATUS_OK;
                    n_rsp.slot_index = SW'(free_idx);
                end else begin
                    n_rsp.status = ostst_pkg::STATUS_FULL;
                end
            end
            ostst_pkg::CMD_DELETE: begin
                if ({1'b0, r_req.slot_sel} < (SW+1)'(N)) begin
                    n_busy[sel_idx] = 1'b0;
                end
                n_rsp.status = ostst_pkg::STATUS_OK;
            end
            ostst_pkg::CMD_TICK: begin
                n_tick       = tick_inc;
                n_rsp.status = ostst_pkg::STATUS_OK;
                if (fire_hit) begin
                    n_busy[fire_idx]    = 1'b0;
                    n_rsp.slot_index    = SW'(fire_idx);
                    n_rsp.fired         = 1'b1;
                    n_rsp.fired_handler = r_handler[fire_idx];
                    n_rsp.fired_arg     = r_arg[fire_idx];
                end
            end
            default: n_rsp.status = ostst_pkg::STATUS_BAD;
        endcase
        n_rsp.tick_now = n_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_busy <= '0;
        end else if (i_ctl.execute) begin
            r_tick <= n_tick;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_req <= i_req_data;
        end
        if (i_ctl.execute) begin
            r_rsp <= n_rsp;
            if (create_wr) begin
                r_deadline[free_idx] <= r_tick + r_req.timeout_ticks;
                r_handler[free_idx]  <= r_req.handler_id;
                r_arg[free_idx]      <= r_req.handler_arg;
            end
        end
    end

    assign o_rsp_data = r_rsp;

endmodule

[rtl/one_shot_timer_slot_table.sv]
// ----------------------------------------------------------------------------
// One-shot timer slot table: top level
// Ten one-shot timer slots driven by a 32-bit tick counter.
// ----------------------------------------------------------------------------
// Channels: i_req carries one request (create, delete or tick) per handshake;
// o_rsp returns exactly one response per request, in order.
// A request is captured in the idle state and executed in the execute step;
// a new request is not taken until the last one has been executed. The
// execute step settles the free-slot search, the ten deadline compares
// against the incremented counter and the due-slot priority pick.
// The response is registered and appears the cycle after execution; a new
// request may be taken while that response still waits.
// If the receiver stalls, the response holds and the next request waits in
// the execute step until the response register is free.
// Reset (synchronous, active low) clears the tick counter, frees all slots
// and drops response valid; slot contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ostst_req_if.sink   i_req,
    ostst_rsp_if.source o_rsp
);

    ostst_pkg::t_ctl ctl;

    ostst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_ctl       (ctl)
    );

    ostst_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_req_data (i_req.data),
        .o_rsp_data (o_rsp.data)
    );

endmodule

[rtl/ostst_checker.sv]
// ----------------------------------------------------------------------------
// One-shot timer slot table: port checker
// Checks response consistency and request pacing at the top-level ports.
// ----------------------------------------------------------------------------
`include "one_shot_timer_slot_table_defines.svh"

module ostst_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input ostst_pkg::t_rsp i_rsp
);

    `OSTST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `OSTST_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `OSTST_ASSERT_IMP(a_fire_ok, i_clk, i_rst_n, i_out_valid && i_rsp.fired, (i_rsp.status == ostst_pkg::STATUS_OK) && (i_rsp.fired_handler != 32'd0))
    `OSTST_ASSERT_IMP(a_nofire_clean, i_clk, i_rst_n, i_out_valid && !i_rsp.fired, (i_rsp.fired_handler == 32'd0) && (i_rsp.fired_arg == 32'd0))

endmodule

bind one_shot_timer_slot_table ostst_checker u_ostst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);
